[hw/rtl/utf8_to_utf16_decoder_macros.svh]
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Shared property forms for the decoder's checker.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication, off while reset is high
`define UTD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, off while reset is high
`define UTD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define UTD_ASSERT_ALWAYS_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

[hw/rtl/utd_pkg.sv]
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Decode modes, error codes, the front-to-back job record and constants.
// ---------------------------------------------------------------------------
package utd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_GATHER  = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BAD_SEQ = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;
  localparam logic [1:0] ERR_TRUNC   = 2'd3;

  localparam logic [30:0] REPLACEMENT = 31'h000FFFD;
  localparam logic [30:0] NONCHAR_FE  = 31'h000FFFE;
  localparam logic [30:0] NONCHAR_FF  = 31'h000FFFF;
  localparam logic [30:0] MAX_CODE    = 31'h010FFFF;
  localparam logic [20:0] SURR_OFFSET = 21'h10000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  // One decoded outcome handed from front to back
  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  err;
    logic        last;
  } job_t;

  // Shortest-form minimum for a sequence length
  function automatic logic [30:0] min_for_len(input logic [2:0] len);
    logic [30:0] m;
    case (len)
      3'd2:    m = 31'h0000080;
      3'd3:    m = 31'h0000800;
      3'd4:    m = 31'h0010000;
      3'd5:    m = 31'h0200000;
      3'd6:    m = 31'h4000000;
      default: m = 31'h0000080;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/utd_byte_if.sv]
// ---------------------------------------------------------------------------
// UTF-8 byte channel
// Valid/ready channel carrying one byte and an end-of-string flag.
// ---------------------------------------------------------------------------
interface utd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

[hw/rtl/utd_unit_if.sv]
// ---------------------------------------------------------------------------
// UTF-16 unit channel
// Valid/ready channel carrying one code unit with its status flags.
// ---------------------------------------------------------------------------
interface utd_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  error_kind;
  logic        run_last;
  logic        string_end;

  modport source (output valid, output code_unit, output error_kind,
                  output run_last, output string_end, input ready);
  modport sink (input valid, input code_unit, input error_kind,
                input run_last, input string_end, output ready);
endinterface

[hw/rtl/utd_fifo.sv]
// ---------------------------------------------------------------------------
// Decoder job queue
// Small register queue between the byte front and the unit back.
// ---------------------------------------------------------------------------
module utd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utd_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output utd_pkg::job_t dout,
  output logic          empty
);
  import utd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

[hw/rtl/utd_front.sv]
// ---------------------------------------------------------------------------
// Decoder front end
// Takes UTF-8 bytes, tracks the sequence state and queues decoded outcomes.
// ---------------------------------------------------------------------------
module utd_front (
  input  logic          clk,
  input  logic          rst,
  utd_byte_if.sink      byte_ch,
  output utd_pkg::job_t job,
  output logic          job_push,
  input  logic          job_full
);
  import utd_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [30:0] gval;
  logic [30:0] gval_next;
  logic [2:0]  remaining;
  logic [2:0]  remaining_next;
  logic [2:0]  seq_len;
  logic [2:0]  seq_len_next;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        cont_ok;
  logic        final_cont;
  logic [30:0] gval_shift;
  logic [30:0] fixed_val;
  logic        range_err;
  logic [2:0]  lead_len;
  logic [7:0]  lead_bits;
  logic        want_push;

  assign byte_ch.ready = !job_full;
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign b             = byte_ch.byte_in;
  assign last          = byte_ch.last_byte;
  assign cont_ok       = (b[7:6] == 2'b10);
  assign final_cont    = (remaining <= 3'd1);
  assign gval_shift    = {gval[24:0], b[5:0]};

  // Replace overlong forms and the two noncharacters, then range check
  always_comb begin
    if ((gval_shift < min_for_len(seq_len)) || (gval_shift == NONCHAR_FE) ||
        (gval_shift == NONCHAR_FF)) begin
      fixed_val = REPLACEMENT;
    end else begin
      fixed_val = gval_shift;
    end
    range_err = (fixed_val > MAX_CODE);
  end

  // Classify a lead byte by its run of leading ones
  always_comb begin
    if (b inside {[8'hC0:8'hDF]}) begin
      lead_len = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      lead_len = 3'd3;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      lead_len = 3'd4;
    end else if (b inside {[8'hF8:8'hFB]}) begin
      lead_len = 3'd5;
    end else if (b inside {[8'hFC:8'hFD]}) begin
      lead_len = 3'd6;
    end else begin
      lead_len = 3'd0;
    end
    lead_bits = b & (8'hFF >> (lead_len + 3'd1));
  end

  // Next decode mode
  always_comb begin
    case (mode)
      MODE_GATHER: begin
        if (!cont_ok) begin
          mode_next = last ? MODE_IDLE : MODE_DISCARD;
        end else if (final_cont) begin
          mode_next = (range_err && !last) ? MODE_DISCARD : MODE_IDLE;
        end else begin
          mode_next = last ? MODE_IDLE : MODE_GATHER;
        end
      end
      MODE_DISCARD: begin
        mode_next = last ? MODE_IDLE : MODE_DISCARD;
      end
      default: begin
        if (b[7] && !last) begin
          mode_next = (lead_len == 3'd0) ? MODE_DISCARD : MODE_GATHER;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
    endcase
  end

  // Outcome of this byte and the gathered state
  always_comb begin
    want_push      = 1'b0;
    job.code_point = '0;
    job.err        = ERR_NONE;
    job.last       = last;
    gval_next      = gval;
    remaining_next = remaining;
    seq_len_next   = seq_len;
    case (mode)
      MODE_GATHER: begin
        if (!cont_ok) begin
          want_push = 1'b1;
          job.err   = ERR_BAD_SEQ;
        end else begin
          gval_next = gval_shift;
          if (final_cont) begin
            remaining_next = '0;
            want_push      = 1'b1;
            if (range_err) begin
              job.err = ERR_RANGE;
            end else begin
              job.code_point = fixed_val[20:0];
            end
          end else begin
            remaining_next = remaining - 3'd1;
            if (last) begin
              want_push = 1'b1;
              job.err   = ERR_TRUNC;
            end
          end
        end
      end
      MODE_DISCARD: begin
        want_push = 1'b0;
      end
      default: begin
        if (!b[7]) begin
          want_push      = 1'b1;
          job.code_point = {13'd0, b};
        end else if (lead_len == 3'd0) begin
          want_push = 1'b1;
          job.err   = ERR_BAD_SEQ;
        end else if (last) begin
          want_push = 1'b1;
          job.err   = ERR_TRUNC;
        end else begin
          gval_next      = {23'd0, lead_bits};
          seq_len_next   = lead_len;
          remaining_next = lead_len - 3'd1;
        end
      end
    endcase
  end

  assign job_push = accept && want_push;

  // Hold decode state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      gval      <= '0;
      remaining <= '0;
      seq_len   <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      gval      <= gval_next;
      remaining <= remaining_next;
      seq_len   <= seq_len_next;
    end
  end
endmodule

[hw/rtl/utd_back.sv]
// ---------------------------------------------------------------------------
// Decoder back end
// Turns queued outcomes into UTF-16 units, splitting surrogate pairs.
// ---------------------------------------------------------------------------
module utd_back (
  input  logic          clk,
  input  logic          rst,
  input  utd_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_pop,
  utd_unit_if.source    unit_ch
);
  import utd_pkg::*;

  logic        out_valid;
  logic [15:0] out_unit;
  logic [1:0]  out_err;
  logic        out_run_last;
  logic        out_end;
  logic        phase;

  logic        load;
  logic        is_pair;
  logic [20:0] offs;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;

  assign load    = !out_valid || unit_ch.ready;
  assign is_pair = (job.err == ERR_NONE) && (job.code_point[20:16] != 5'd0);
  assign offs    = job.code_point - SURR_OFFSET;
  assign hi_unit = HI_SURR + {6'd0, offs[19:10]};
  assign lo_unit = LO_SURR + {6'd0, offs[9:0]};
  assign job_pop = load && !job_empty && (phase || !is_pair);

  // Output valid and pair phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      if (phase) begin
        out_valid <= 1'b1;
        phase     <= 1'b0;
      end else if (!job_empty) begin
        out_valid <= 1'b1;
        phase     <= is_pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (phase) begin
        out_unit     <= lo_unit;
        out_err      <= ERR_NONE;
        out_run_last <= 1'b1;
        out_end      <= job.last;
      end else if (job.err != ERR_NONE) begin
        out_unit     <= '0;
        out_err      <= job.err;
        out_run_last <= 1'b1;
        out_end      <= job.last;
      end else if (is_pair) begin
        out_unit     <= hi_unit;
        out_err      <= ERR_NONE;
        out_run_last <= 1'b0;
        out_end      <= 1'b0;
      end else begin
        out_unit     <= job.code_point[15:0];
        out_err      <= ERR_NONE;
        out_run_last <= 1'b1;
        out_end      <= job.last;
      end
    end
  end

  assign unit_ch.valid      = out_valid;
  assign unit_ch.code_unit  = out_unit;
  assign unit_ch.error_kind = out_err;
  assign unit_ch.run_last   = out_run_last;
  assign unit_ch.string_end = out_end;
endmodule

[hw/rtl/utf8_to_utf16_decoder.sv]
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Byte-serial decoder with a queue between the byte front and unit back.
// ---------------------------------------------------------------------------
// The block accepts one UTF-8 byte per clock while the job queue is not full,
// and writes each decoded outcome into the job queue at the edge that accepts
// the byte; the back end turns the head job into a registered result whenever
// its output register is free, and a surrogate pair leaves as two results, high
// unit first. Since a pair only comes from a four-byte sequence, two results for
// four bytes, with the sink ready the input runs at one byte per cycle
// indefinitely; a stalled sink fills the queue (QUEUE_DEPTH jobs plus the output
// register) before the input stops.
module utf8_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  utd_byte_if.sink   byte_ch,
  utd_unit_if.source unit_ch
);
  import utd_pkg::*;

  job_t push_job;
  job_t head_job;
  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;

  utd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .job      (push_job),
    .job_push (job_push),
    .job_full (job_full)
  );

  utd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (push_job),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (head_job),
    .empty (job_empty)
  );

  utd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .unit_ch   (unit_ch)
  );
endmodule

[hw/rtl/utd_checker.sv]
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_macros.svh"

module utd_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [15:0] code_unit,
  input logic [1:0]  error_kind,
  input logic        run_last,
  input logic        string_end
);
  import utd_pkg::*;

  // Error results carry no unit
  `UTD_ASSERT_IMP(err_zero_unit, clk, rst, valid && (error_kind != ERR_NONE), code_unit == 16'd0)

  // A result that is not the last of its byte is always a high surrogate
  `UTD_ASSERT_IMP(mid_is_high, clk, rst, valid && !run_last, (error_kind == ERR_NONE) && (code_unit[15:10] == 6'b110110))

  // End of string only on the last result of a byte
  `UTD_ASSERT_IMP(end_on_last, clk, rst, valid && string_end, run_last)

  // Hold a stalled result
  `UTD_ASSERT_NXT(hold_stall, clk, rst, valid && !ready, valid && $stable(code_unit) && $stable(error_kind))

  // Nothing offered right after reset
  `UTD_ASSERT_ALWAYS_NXT(quiet_reset, clk, rst, !valid)
endmodule

bind utf8_to_utf16_decoder utd_checker u_utd_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (unit_ch.valid),
  .ready      (unit_ch.ready),
  .code_unit  (unit_ch.code_unit),
  .error_kind (unit_ch.error_kind),
  .run_last   (unit_ch.run_last),
  .string_end (unit_ch.string_end)
);
